FILE: rtl/ocd_pkg.sv
// shared types and constants of the osc message decoder
package ocd_pkg;

	typedef enum logic [2:0] {
		K_ADDR = 3'd0,
		K_INT  = 3'd1,
		K_F32  = 3'd2,
		K_F64  = 3'd3,
		K_SCHR = 3'd4,
		K_SEND = 3'd5,
		K_ERR  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		T_I = 2'd0,
		T_F = 2'd1,
		T_S = 2'd2,
		T_D = 2'd3
	} tag_t;

	typedef enum logic [6:0] {
		PH_ADDR = 7'b0000001,
		PH_SKIP = 7'b0000010,
		PH_TAGS = 7'b0000100,
		PH_TPAD = 7'b0001000,
		PH_ARGS = 7'b0010000,
		PH_SPAD = 7'b0100000,
		PH_DONE = 7'b1000000
	} phase_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_D     = 8'h64;

	// error flags
	localparam int ERR_TRUNC = 0;
	localparam int ERR_OVF   = 1;

	// one classified byte beat
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_nul;
		logic       is_comma;
		logic       tag_hit;
		tag_t       tag_code;
	} item_t;

endpackage

FILE: rtl/ocd_ram.sv
// generic single write port ram with registered read
module ocd_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/ocd_front.sv
// front end: takes input beats and classifies each byte
module ocd_front (
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	input  logic           is_last,
	input  logic           q_full,
	output logic           q_push,
	output ocd_pkg::item_t q_item
);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item          = '0;
		q_item.data     = data_byte;
		q_item.last     = is_last;
		q_item.is_nul   = (data_byte == ocd_pkg::CH_NUL);
		q_item.is_comma = (data_byte == ocd_pkg::CH_COMMA);
		q_item.tag_hit  = 1'b1;
		q_item.tag_code = ocd_pkg::T_I;
		unique case (data_byte)
			ocd_pkg::CH_I: q_item.tag_code = ocd_pkg::T_I;
			ocd_pkg::CH_F: q_item.tag_code = ocd_pkg::T_F;
			ocd_pkg::CH_S: q_item.tag_code = ocd_pkg::T_S;
			ocd_pkg::CH_D: q_item.tag_code = ocd_pkg::T_D;
			default:       q_item.tag_hit  = 1'b0;
		endcase
	end

endmodule

FILE: rtl/ocd_queue.sv
// two entry queue of classified beats between front and back
module ocd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ocd_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output ocd_pkg::item_t q_item
);

	ocd_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/ocd_back.sv
// back end: message parser state, tag store and output register
module ocd_back #(
	parameter int MAX_TAGS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  ocd_pkg::item_t q_item,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     kind,
	output logic [63:0]    value,
	output logic           msg_end
);

	localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
	localparam int CW = $clog2(MAX_TAGS + 1);

	ocd_pkg::phase_t phase_q, phase_d;
	logic [1:0]      pos_q, npos;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   idx_q, idx_d, idx_inc;
	logic [2:0]      bg_q, bg_d;
	logic            ovf_q, ovf_d;
	logic [63:0]     acc_q, acc_d;

	logic            step;
	logic            have;
	ocd_pkg::kind_t  kind_c;
	logic [63:0]     val_c;
	logic            tag_we;
	logic [1:0]      rd_code;
	logic [1:0]      err;
	logic            more_now, more_inc, need8, full_word;

	logic            out_valid_q;
	ocd_pkg::kind_t  kind_q;
	logic [63:0]     value_q;
	logic            msg_end_q;

	assign step  = q_valid && (!out_valid_q || out_ready);
	assign q_pop = step;

	ocd_ram #(
		.WIDTH(2),
		.DEPTH(MAX_TAGS)
	) u_tags (
		.clk   (clk),
		.we    (tag_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (q_item.tag_code),
		.raddr (step ? idx_d[AW-1:0] : idx_q[AW-1:0]),
		.rdata (rd_code)
	);

	always_comb begin
		npos      = pos_q + 2'd1;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		bg_d      = bg_q;
		ovf_d     = ovf_q;
		acc_d     = acc_q;
		have      = 1'b0;
		kind_c    = ocd_pkg::K_ADDR;
		val_c     = '0;
		tag_we    = 1'b0;
		err       = 2'b00;
		idx_inc   = idx_q + CW'(1);
		more_now  = (idx_q < cnt_q);
		more_inc  = (idx_inc < cnt_q);
		need8     = (rd_code == ocd_pkg::T_D);
		full_word = need8 ? (bg_q == 3'd7) : (bg_q == 3'd3);
		unique case (phase_q)
			ocd_pkg::PH_ADDR: begin
				if (q_item.is_nul) begin
					phase_d = ocd_pkg::PH_SKIP;
				end else begin
					have  = 1'b1;
					val_c = {56'd0, q_item.data};
				end
			end
			ocd_pkg::PH_SKIP: begin
				if (q_item.is_comma) begin
					phase_d = ocd_pkg::PH_TAGS;
				end
			end
			ocd_pkg::PH_TAGS: begin
				if (q_item.is_nul) begin
					if (npos != 2'd0) begin
						phase_d = ocd_pkg::PH_TPAD;
					end else begin
						phase_d = more_now ? ocd_pkg::PH_ARGS : ocd_pkg::PH_DONE;
					end
				end else if (q_item.tag_hit) begin
					if (cnt_q < CW'(MAX_TAGS)) begin
						tag_we = step;
						cnt_d  = cnt_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
				end
			end
			ocd_pkg::PH_TPAD, ocd_pkg::PH_SPAD: begin
				if (npos == 2'd0) begin
					phase_d = more_now ? ocd_pkg::PH_ARGS : ocd_pkg::PH_DONE;
				end
			end
			ocd_pkg::PH_ARGS: begin
				if (rd_code == ocd_pkg::T_S) begin
					have = 1'b1;
					if (!q_item.is_nul) begin
						kind_c = ocd_pkg::K_SCHR;
						val_c  = {56'd0, q_item.data};
					end else begin
						kind_c = ocd_pkg::K_SEND;
						idx_d  = idx_inc;
						if (npos != 2'd0) begin
							phase_d = ocd_pkg::PH_SPAD;
						end else begin
							phase_d = more_inc ? ocd_pkg::PH_ARGS : ocd_pkg::PH_DONE;
						end
					end
				end else begin
					acc_d = {acc_q[55:0], q_item.data};
					if (full_word) begin
						have  = 1'b1;
						val_c = need8 ? acc_d : {32'd0, acc_d[31:0]};
						unique case (rd_code)
							ocd_pkg::T_I: kind_c = ocd_pkg::K_INT;
							ocd_pkg::T_F: kind_c = ocd_pkg::K_F32;
							default:      kind_c = ocd_pkg::K_F64;
						endcase
						bg_d  = 3'd0;
						idx_d = idx_inc;
						if (!more_inc) begin
							phase_d = ocd_pkg::PH_DONE;
						end
					end else begin
						bg_d = bg_q + 3'd1;
					end
				end
			end
			default: begin
			end
		endcase
		if (q_item.last) begin
			err[ocd_pkg::ERR_TRUNC] = (phase_d != ocd_pkg::PH_DONE);
			err[ocd_pkg::ERR_OVF]   = ovf_d;
			phase_d = ocd_pkg::PH_ADDR;
			cnt_d   = '0;
			idx_d   = '0;
			bg_d    = 3'd0;
			ovf_d   = 1'b0;
			if (err != 2'b00) begin
				have   = 1'b1;
				kind_c = ocd_pkg::K_ERR;
				val_c  = {62'd0, err};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ocd_pkg::PH_ADDR;
			pos_q       <= 2'd0;
			cnt_q       <= '0;
			idx_q       <= '0;
			bg_q        <= 3'd0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_d;
				pos_q       <= q_item.last ? 2'd0 : npos;
				cnt_q       <= cnt_d;
				idx_q       <= idx_d;
				bg_q        <= bg_d;
				ovf_q       <= ovf_d;
				out_valid_q <= have;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (step) begin
			acc_q <= acc_d;
			if (have) begin
				kind_q    <= kind_c;
				value_q   <= val_c;
				msg_end_q <= q_item.last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign msg_end   = msg_end_q;

endmodule

FILE: rtl/osc_message_decoder.sv
// top level of the osc message decoder
//
//  channel  signals                          beat
//  in       in_valid in_ready                data_byte, is_last
//  out      out_valid out_ready              kind, value, msg_end
//
// one byte beat per cycle sustained while the output is not stalled, zero or one result per byte
// a byte passes through the queue and then the parser step, which registers the result
// the parser does one byte per cycle while not stalled; the tag store is a ram read one step ahead
// reset clears parser state and queue; the tag store holds no reset value
// a stalled output holds the parser; the two entry queue keeps taking input meanwhile until it fills
module osc_message_decoder #(
	parameter int MAX_TAGS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [63:0] value,
	output logic        msg_end
);

	logic           q_full;
	logic           q_push;
	ocd_pkg::item_t push_item;
	logic           q_pop;
	logic           q_valid;
	ocd_pkg::item_t q_item;

	ocd_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.is_last   (is_last),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	ocd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	ocd_back #(
		.MAX_TAGS(MAX_TAGS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value     (value),
		.msg_end   (msg_end)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ocd_pkg::K_ERR |-> msg_end && value[63:2] == 62'd0)
		else $error("error beat not closing message");

	a_char_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == ocd_pkg::K_ADDR || kind == ocd_pkg::K_SCHR)
			|-> value[63:8] == 56'd0)
		else $error("character beat wider than a byte");

	a_word_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == ocd_pkg::K_INT || kind == ocd_pkg::K_F32)
			|-> value[63:32] == 32'd0)
		else $error("32-bit value not zero extended");

	a_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ocd_pkg::K_SEND |-> value == 64'd0)
		else $error("string end carries a value");

endmodule
